### design/swss_pkg.sv
// shared types, constants and the segment table for the stopwatch display scanner
package swss_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int DIGIT_W = 3;
    localparam int CENTI_W = 7;
    localparam int SEC_W = 14;
    localparam int PRESCALE_W = 8;
    localparam int SEG_W = 8;
    localparam int BCD_W = 4;

    localparam logic [CENTI_W-1:0] CENTI_LAST = 7'd99;
    localparam logic [SEC_W-1:0] SEC_LAST = 14'd9999;
    localparam logic [BCD_W-1:0] BCD_LAST = 4'd9;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd5;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

    localparam logic [DIGIT_W-1:0] DIG_CENTI_LO = 3'd0;
    localparam logic [DIGIT_W-1:0] DIG_CENTI_HI = 3'd1;
    localparam logic [DIGIT_W-1:0] DIG_SEC_1 = 3'd2;
    localparam logic [DIGIT_W-1:0] DIG_SEC_10 = 3'd3;
    localparam logic [DIGIT_W-1:0] DIG_SEC_100 = 3'd4;
    localparam logic [DIGIT_W-1:0] DIG_SEC_1000 = 3'd5;
    localparam logic [DIGIT_W-1:0] DIG_LAST = 3'(NUM_DIGITS - 1);

    typedef struct packed {
        logic reset_press;
        logic start_press;
    } swss_keys_t;

    // digit 0 is units of hundredths, digit 5 thousands of seconds
    typedef struct packed {
        logic                             running;
        logic [CENTI_W-1:0]               centi;
        logic [SEC_W-1:0]                 sec;
        logic [NUM_DIGITS-1:0][BCD_W-1:0] digit;
    } swss_count_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] value);
        logic [SEG_W-1:0] code;
        case (value)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

### design/swss_debounce.sv
// key debounce shift register with press edge detect
module swss_debounce #(
    parameter int SAMPLES = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic level,
    output logic press
);
    logic [SAMPLES-1:0] hist_reg;
    logic [SAMPLES-1:0] hist_next;
    logic               stable_reg;
    logic               stable_next;

    assign hist_next = {hist_reg[SAMPLES-2:0], level};

    always_comb
    begin
        stable_next = stable_reg;
        if (hist_next == '0)
        begin
            stable_next = 1'b0;
        end
        else if (hist_next == '1)
        begin
            stable_next = 1'b1;
        end
    end

    // released to pressed
    assign press = step && stable_reg && !stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '1;
            stable_reg <= 1'b1;
        end
        else if (step)
        begin
            hist_reg   <= hist_next;
            stable_reg <= stable_next;
        end
    end

endmodule

### design/swss_timer.sv
// run flag, prescaler and binary plus bcd time counters
module swss_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  swss_pkg::swss_keys_t              keys,
    input  logic [swss_pkg::PRESCALE_W-1:0]   ticks_per_hundredth,
    output swss_pkg::swss_count_t             count_next
);
    import swss_pkg::*;

    swss_count_t             count_reg;
    swss_count_t             base;
    logic [PRESCALE_W-1:0]   prescale_reg;
    logic [PRESCALE_W-1:0]   prescale_next;
    logic [PRESCALE_W:0]     prescale_inc;
    logic                    roll;
    logic                    carry;

    assign prescale_inc = {1'b0, prescale_reg} + 1'b1;
    assign roll = prescale_inc >= {1'b0, ticks_per_hundredth};
    assign prescale_next = roll ? '0 : prescale_inc[PRESCALE_W-1:0];

    always_comb
    begin
        base = count_reg;
        if (keys.reset_press)
        begin
            base = '0;
        end
        if (keys.start_press)
        begin
            base.running = !base.running;
        end

        count_next = base;
        if (roll && base.running)
        begin
            if (base.centi == CENTI_LAST)
            begin
                count_next.centi = '0;
                if (base.sec == SEC_LAST)
                begin
                    count_next.sec = '0;
                end
                else
                begin
                    count_next.sec = base.sec + 1'b1;
                end
            end
            else
            begin
                count_next.centi = base.centi + 1'b1;
            end

            // bcd ripple, one digit per stage of the chain
            carry = 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (carry)
                begin
                    if (base.digit[i] == BCD_LAST)
                    begin
                        count_next.digit[i] = '0;
                    end
                    else
                    begin
                        count_next.digit[i] = base.digit[i] + 1'b1;
                        carry = 1'b0;
                    end
                end
            end
        end
        else
        begin
            carry = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prescale_reg <= '0;
        end
        else if (step)
        begin
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
        end
    end

endmodule

### design/swss_seg.sv
// digit select to segment pattern with leading zero blanking
module swss_seg (
    input  swss_pkg::swss_count_t             count,
    input  logic [swss_pkg::DIGIT_W-1:0]      scan,
    output logic [swss_pkg::SEG_W-1:0]        pattern
);
    import swss_pkg::*;

    logic hi3_zero;
    logic hi2_zero;
    logic hi1_zero;

    assign hi1_zero = count.digit[5] == '0;
    assign hi2_zero = hi1_zero && (count.digit[4] == '0);
    assign hi3_zero = hi2_zero && (count.digit[3] == '0);

    always_comb
    begin
        case (scan)
            DIG_CENTI_LO: pattern = seg_code(count.digit[0]);
            DIG_CENTI_HI: pattern = seg_code(count.digit[1]);
            DIG_SEC_1:    pattern = seg_code(count.digit[2]) & SEG_DP_MASK;
            DIG_SEC_10:   pattern = hi3_zero ? SEG_BLANK : seg_code(count.digit[3]);
            DIG_SEC_100:  pattern = hi2_zero ? SEG_BLANK : seg_code(count.digit[4]);
            DIG_SEC_1000: pattern = hi1_zero ? SEG_BLANK : seg_code(count.digit[5]);
            default:      pattern = SEG_BLANK;
        endcase
    end

endmodule

### design/stopwatch_seven_segment_scan.sv
// Stopwatch with a six-digit multiplexed seven-segment scan output. Every input
// word is one scan tick carrying the raw reset and start/stop key levels; every
// tick yields exactly one output word with the digit driven on this tick, its
// active-low segment pattern and the count as it stands after the tick. A word
// passes an input register and an output register and its result is valid once
// the output register has taken it; one word is taken per cycle while the output
// side keeps up, the limit being the combinational key, prescaler and bcd update
// between the two registers. The hundredth rate register may only be written
// while no word is in flight.
module stopwatch_seven_segment_scan #(
    parameter int DEBOUNCE_SAMPLES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // ticks_per_hundredth
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // reset_key_level, start_key_level, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // digit_select, segment_pattern, is_running,
                                        // hundredths_shown, seconds_shown, zero fill
);
    import swss_pkg::*;

    localparam int OUT_W = DIGIT_W + SEG_W + 1 + CENTI_W + SEC_W;

    logic                   in_valid_reg;
    logic                   reset_level_reg;
    logic                   start_level_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;
    logic [PRESCALE_W-1:0]  tph_reg;
    logic [DIGIT_W-1:0]     scan_reg;
    logic [DIGIT_W-1:0]     scan_next;
    logic                   advance;
    logic                   step;
    swss_keys_t             keys;
    swss_count_t            count_next;
    logic [SEG_W-1:0]       pattern;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(40 - OUT_W){1'b0}}, out_data_reg};

    swss_debounce #(
        .SAMPLES (DEBOUNCE_SAMPLES)
    ) u_reset_key (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .level (reset_level_reg),
        .press (keys.reset_press)
    );

    swss_debounce #(
        .SAMPLES (DEBOUNCE_SAMPLES)
    ) u_start_key (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .level (start_level_reg),
        .press (keys.start_press)
    );

    swss_timer u_timer (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (step),
        .keys                (keys),
        .ticks_per_hundredth (tph_reg),
        .count_next          (count_next)
    );

    swss_seg u_seg (
        .count   (count_next),
        .scan    (scan_reg),
        .pattern (pattern)
    );

    assign scan_next = (scan_reg >= DIG_LAST) ? '0 : scan_reg + 1'b1;
    assign out_data_next = {count_next.sec, count_next.centi, count_next.running,
                            pattern, scan_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tph_reg <= PRESCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tph_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                scan_reg <= scan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            reset_level_reg <= s_axis_tdata[0];
            start_level_reg <= s_axis_tdata[1];
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
